>>> rtl/core/rfm_pkg.sv
// ----------------------------------------------------------------------------
// rfm_pkg
// shared types and constants of the rank filtered mean block
// ----------------------------------------------------------------------------
package rfm_pkg;

	localparam int MAX_SAMPLES_DEF = 256;
	localparam int SAMPLE_W        = 32;
	localparam int RANK_W          = 8;
	localparam int KEPT_W          = 9;
	localparam int KEPT_SAT        = 511;

	localparam logic [RANK_W-1:0] MIN_RANK_RST = 8'd5;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} rfm_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mean;
		logic [KEPT_W-1:0]          kept_count;
		logic                       none_kept;
	} rfm_out_t;

endpackage

>>> rtl/core/rfm_ram.sv
// ----------------------------------------------------------------------------
// rfm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/rfm_rank.sv
// ----------------------------------------------------------------------------
// rfm_rank
// rank sequencer: for each stored sample scans the store, counts the
// others at or below it and accumulates the samples that reach min_rank
// ----------------------------------------------------------------------------
module rfm_rank #(
	parameter int MAX_SAMPLES = rfm_pkg::MAX_SAMPLES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0]   n,
	input  logic [rfm_pkg::RANK_W-1:0]         min_rank,
	output logic [$clog2(MAX_SAMPLES)-1:0]     raddr,
	input  logic [rfm_pkg::SAMPLE_W-1:0]       rdata,
	output logic                               done,
	output logic signed [rfm_pkg::SAMPLE_W+$clog2(MAX_SAMPLES):0] sum,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]   kept
);

	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SW    = rfm_pkg::SAMPLE_W;
	localparam int SUM_W = SW + AW + 1;
	localparam int CMP_W = (CNT_W > rfm_pkg::RANK_W) ? CNT_W : rfm_pkg::RANK_W;

	typedef enum logic [5:0] {
		RK_IDLE  = 6'b000001,
		RK_FETCH = 6'b000010,
		RK_LATCH = 6'b000100,
		RK_SCAN  = 6'b001000,
		RK_TAIL  = 6'b010000,
		RK_ACC   = 6'b100000
	} rk_state_t;

	rk_state_t              state_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       i_q;
	logic [CNT_W-1:0]       j_q;
	logic [CNT_W-1:0]       rank_q;
	logic [CNT_W-1:0]       kept_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SW-1:0]   xi_q;
	logic                   done_q;
	logic                   pend_s1;
	logic [CNT_W-1:0]       jidx_s1;
	logic [CNT_W-1:0]       last_idx;
	logic                   hit;

	assign last_idx = n_q - CNT_W'(1);
	assign raddr    = (state_q == RK_SCAN) ? j_q[AW-1:0] : i_q[AW-1:0];
	// the sample itself does not count, equal values do
	assign hit      = pend_s1 && (jidx_s1 != i_q) && ($signed(rdata) <= xi_q);

	assign done = done_q;
	assign sum  = sum_q;
	assign kept = kept_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RK_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			rank_q  <= '0;
			kept_q  <= '0;
			sum_q   <= '0;
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			if (hit) begin
				rank_q <= rank_q + CNT_W'(1);
			end
			unique case (state_q)
				RK_IDLE: begin
					if (start) begin
						n_q     <= n;
						i_q     <= '0;
						sum_q   <= '0;
						kept_q  <= '0;
						state_q <= RK_FETCH;
					end
				end
				RK_FETCH: begin
					state_q <= RK_LATCH;
				end
				RK_LATCH: begin
					j_q     <= '0;
					rank_q  <= '0;
					state_q <= RK_SCAN;
				end
				RK_SCAN: begin
					pend_s1 <= 1'b1;
					j_q     <= j_q + CNT_W'(1);
					if (j_q == last_idx) begin
						state_q <= RK_TAIL;
					end
				end
				RK_TAIL: begin
					state_q <= RK_ACC;
				end
				RK_ACC: begin
					if (CMP_W'(rank_q) >= CMP_W'(min_rank)) begin
						sum_q  <= sum_q + {{(SUM_W-SW){xi_q[SW-1]}}, xi_q};
						kept_q <= kept_q + CNT_W'(1);
					end
					i_q <= i_q + CNT_W'(1);
					if (i_q == last_idx) begin
						done_q  <= 1'b1;
						state_q <= RK_IDLE;
					end else begin
						state_q <= RK_FETCH;
					end
				end
				default: begin
					state_q <= RK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		jidx_s1 <= j_q;
		if (state_q == RK_LATCH) begin
			xi_q <= $signed(rdata);
		end
	end

endmodule

>>> rtl/core/rfm_div.sv
// ----------------------------------------------------------------------------
// rfm_div
// restoring divider, one quotient bit per cycle, signed dividend over an
// unsigned nonzero divisor, quotient truncated toward zero
// ----------------------------------------------------------------------------
module rfm_div #(
	parameter int DIVIDEND_W = 41,
	parameter int DIVISOR_W  = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]         divisor,
	output logic                         done,
	output logic [rfm_pkg::SAMPLE_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic                  neg_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    r_shift;
	logic [DIVISOR_W:0]    r_diff;
	logic                  q_bit;
	logic [DIVIDEND_W-1:0] mag;
	logic [DIVIDEND_W-1:0] q_fin;

	assign mag     = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
	assign r_shift = {rem_q, quo_q[DIVIDEND_W-1]};
	assign r_diff  = r_shift - {1'b0, dvs_q};
	assign q_bit   = r_shift >= {1'b0, dvs_q};
	assign q_fin   = neg_q ? DIVIDEND_W'(-quo_q) : quo_q;

	assign done     = done_q;
	assign quotient = q_fin[rfm_pkg::SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[DIVIDEND_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], q_bit};
			// remainder stays below the divisor, so the low bits hold it
			rem_q <= q_bit ? r_diff[DIVISOR_W-1:0] : r_shift[DIVISOR_W-1:0];
		end
	end

endmodule

>>> rtl/core/rank_filtered_mean.sv
// ----------------------------------------------------------------------------
// rank_filtered_mean
// lower trimmed mean over a marked set of samples kept in a sample ram
// ----------------------------------------------------------------------------
// intake: a word not marked last is written to the sample ram, one word a cycle
//   while smp_stall is low; after the last word a rank scan over the ram read
//   port runs, then the bit-serial divider unless no sample was kept
// sets: smp_stall stays high until the result is registered for output
// reset: async active low, clears count, control and min_rank (to 5);
//   sample ram contents are not cleared and need no clearing pass
module rank_filtered_mean #(
	parameter int MAX_SAMPLES = rfm_pkg::MAX_SAMPLES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rfm_pkg::RANK_W-1:0] cfg_wdata,
	input  logic                       smp_valid,
	output logic                       smp_stall,
	input  rfm_pkg::rfm_in_t           smp_word,
	output logic                       res_valid,
	input  logic                       res_stall,
	output rfm_pkg::rfm_out_t          res_word
);

	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = rfm_pkg::SAMPLE_W + AW + 1;
	localparam int KW    = (CNT_W > rfm_pkg::KEPT_W) ? CNT_W : rfm_pkg::KEPT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RANK = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_HOLD = 4'b1000
	} st_t;

	st_t                          state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [rfm_pkg::RANK_W-1:0]   min_rank_q;
	logic                         out_valid_q;
	rfm_pkg::rfm_out_t            out_q;
	rfm_pkg::rfm_out_t            res_q;

	logic                         smp_acc;
	logic                         room;
	logic [CNT_W-1:0]             n_set;
	logic                         ram_we;
	logic [AW-1:0]                raddr;
	logic [rfm_pkg::SAMPLE_W-1:0] rdata;
	logic                         rank_start;
	logic                         rank_done;
	logic signed [SUM_W-1:0]      rank_sum;
	logic [CNT_W-1:0]             rank_kept;
	logic                         div_start;
	logic                         div_done;
	logic [rfm_pkg::SAMPLE_W-1:0] div_q;
	logic [KW-1:0]                kept_ext;
	logic [rfm_pkg::KEPT_W-1:0]   kept_sat;
	logic                         slot_free;

	assign smp_stall  = (state_q != ST_IDLE);
	assign smp_acc    = smp_valid && !smp_stall;
	assign room       = (cnt_q < CNT_W'(MAX_SAMPLES));
	// a word arriving at a full store is dropped but may still close the set
	assign ram_we     = smp_acc && room;
	assign n_set      = room ? cnt_q + CNT_W'(1) : cnt_q;
	assign rank_start = smp_acc && smp_word.last;
	assign div_start  = (state_q == ST_RANK) && rank_done && (rank_kept != '0);
	assign slot_free  = !out_valid_q || !res_stall;

	assign kept_ext = KW'(rank_kept);
	assign kept_sat = (kept_ext > KW'(rfm_pkg::KEPT_SAT)) ?
		rfm_pkg::KEPT_W'(rfm_pkg::KEPT_SAT) : kept_ext[rfm_pkg::KEPT_W-1:0];

	assign res_valid = out_valid_q;
	assign res_word  = out_q;

	rfm_ram #(
		.WIDTH(rfm_pkg::SAMPLE_W),
		.DEPTH(MAX_SAMPLES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (smp_word.sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	rfm_rank #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rank_start),
		.n        (n_set),
		.min_rank (min_rank_q),
		.raddr    (raddr),
		.rdata    (rdata),
		.done     (rank_done),
		.sum      (rank_sum),
		.kept     (rank_kept)
	);

	rfm_div #(
		.DIVIDEND_W(SUM_W),
		.DIVISOR_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rank_sum),
		.divisor  (rank_kept),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			min_rank_q  <= rfm_pkg::MIN_RANK_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_rank_q <= cfg_wdata;
			end
			if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (rank_start) begin
						cnt_q   <= '0;
						state_q <= ST_RANK;
					end else if (ram_we) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_RANK: begin
					if (rank_done) begin
						state_q <= div_start ? ST_DIV : ST_HOLD;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RANK && rank_done) begin
			res_q.mean       <= '0;
			res_q.kept_count <= kept_sat;
			res_q.none_kept  <= (rank_kept == '0);
		end
		if (state_q == ST_DIV && div_done) begin
			res_q.mean <= $signed(div_q);
		end
		if (state_q == ST_HOLD && slot_free) begin
			out_q <= res_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_ram_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("sample ram written while a set is being ranked");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		rank_start |=> (state_q == ST_RANK && cnt_q == '0))
		else $error("last word did not start the rank pass");

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_word.none_kept) |->
		(res_word.kept_count == '0 && res_word.mean == '0))
		else $error("empty result carries a mean or a count");
`endif

endmodule
